### sv/assert_macros.svh
// Assertion macros used by the band-pass filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CBPF_ASSERT(lbl, clk_sig, rstn_sig, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error("%m: check failed");
`define CBPF_NEVER(lbl, clk_sig, rstn_sig, expr) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define CBPF_ASSERT(lbl, clk_sig, rstn_sig, prop)
`define CBPF_NEVER(lbl, clk_sig, rstn_sig, expr)
`endif
`endif

### sv/cbpf_pkg.sv
package cbpf_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_HP_LOAD,
        S_HP_RUN,
        S_LP_LOAD,
        S_LP_RUN,
        S_WAIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

    localparam logic [1:0] CFG_HIGH_PASS_GAIN  = 2'd0;
    localparam logic [1:0] CFG_LOW_PASS_GAIN   = 2'd1;
    localparam logic [1:0] CFG_SECTIONS_IN_USE = 2'd2;

    localparam int HIGH_PASS_GAIN_RESET  = 65503;
    localparam int LOW_PASS_GAIN_RESET   = 28030;
    localparam int SECTIONS_IN_USE_RESET = 3;

endpackage

### sv/cbpf_serial_mul.sv
// Signed operand times unsigned coefficient, one coefficient bit per cycle.
// The result is the product divided by 2^COEF_BITS, rounded to nearest with
// ties towards plus infinity.
module cbpf_serial_mul #(
    parameter int OPER_BITS = 26,
    parameter int COEF_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [OPER_BITS-1:0]  operand,
    input  logic [COEF_BITS-1:0]  coef,
    output cbpf_pkg::mul_status_t status,
    output logic [OPER_BITS:0]    result
);

    localparam int CNT_W = $clog2(COEF_BITS + 1);

    logic [OPER_BITS-1:0] oper_reg;
    logic [OPER_BITS-1:0] acc_reg;
    logic [OPER_BITS-1:0] acc_next;
    logic [COEF_BITS-1:0] coef_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 rnd_reg;
    logic                 rnd_next;
    logic                 busy_reg;
    logic                 done_reg;
    logic [OPER_BITS:0]   step_sum;

    always_comb
    begin
        step_sum = {acc_reg[OPER_BITS-1], acc_reg}
                 + (coef_reg[0] ? {oper_reg[OPER_BITS-1], oper_reg} : '0);
        acc_next = step_sum[OPER_BITS:1];
        rnd_next = step_sum[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !load && busy_reg && (cnt_reg == CNT_W'(1));
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(COEF_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            oper_reg <= operand;
            coef_reg <= coef;
            acc_reg  <= '0;
            rnd_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            rnd_reg  <= rnd_next;
            coef_reg <= coef_reg >> 1;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result      = {acc_reg[OPER_BITS-1], acc_reg} + (OPER_BITS + 1)'(rnd_reg);

endmodule

### sv/cascaded_rc_bandpass_filter.sv
// Band-pass filter for signed acceleration samples: MAX_SECTIONS sections, each a first-order
// RC high-pass followed by a first-order RC low-pass, with the output tapped after section
// sections_in_use (0 passes the sample through, values above MAX_SECTIONS act as
// MAX_SECTIONS). Gains are unsigned fractions with COEF_BITS fractional bits; every section
// result is rounded and saturated. A sample flagged on tuser restarts all sections and comes out
// unchanged. All sections share one bit-serial multiplier that consumes one coefficient bit per
// cycle; an ordinary sample runs a high-pass and a low-pass product through it in every one of
// the MAX_SECTIONS sections, and a restarting sample does not use it. A new sample is taken as
// soon as the previous one is finished, while its result may still wait in the output register;
// configuration writes must only be made while the block is idle.
`include "assert_macros.svh"

module cascaded_rc_bandpass_filter #(
    parameter int MAX_SECTIONS = 4,
    parameter int SAMPLE_BITS  = 24,
    parameter int COEF_BITS    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [COEF_BITS-1:0]                cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: sample.
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // Fields from bit 0: start_req.
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: filtered.
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata
);

    localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int AW        = SAMPLE_BITS + 2;
    localparam int SEC_W     = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int UW        = ($clog2(MAX_SECTIONS + 1) > 3) ? $clog2(MAX_SECTIONS + 1) : 3;

    cbpf_pkg::state_t state_reg;
    cbpf_pkg::state_t state_next;

    logic [COEF_BITS-1:0]   hp_gain_reg;
    logic [COEF_BITS-1:0]   lp_gain_reg;
    logic [2:0]             sections_reg;

    logic [SAMPLE_BITS-1:0] hpi_reg [MAX_SECTIONS];
    logic [SAMPLE_BITS-1:0] hpo_reg [MAX_SECTIONS];
    logic [SAMPLE_BITS-1:0] lpo_reg [MAX_SECTIONS];

    logic [SAMPLE_BITS-1:0] v_reg;
    logic [SAMPLE_BITS-1:0] h_reg;
    logic [SAMPLE_BITS-1:0] tap_reg;
    logic [SEC_W-1:0]       sec_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;

    logic                   accept;
    logic                   mul_load;
    logic                   out_load;
    logic                   hp_write;
    logic                   lp_write;
    logic                   start_write;
    logic                   last_sec;
    logic                   tap_hit;
    logic [UW-1:0]          used;
    logic [AW-1:0]          mul_operand;
    logic [COEF_BITS-1:0]   mul_coef;
    logic [AW:0]            mul_result;
    cbpf_pkg::mul_status_t  mul_stat;
    logic [SAMPLE_BITS-1:0] h_next;
    logic [SAMPLE_BITS-1:0] l_next;

    function automatic logic [AW-1:0] sext(input logic [SAMPLE_BITS-1:0] x);
        return {{2{x[SAMPLE_BITS-1]}}, x};
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sat(input logic [AW+1:0] x);
        logic all_same;
        all_same = (x[AW+1:SAMPLE_BITS-1] == '0) || (x[AW+1:SAMPLE_BITS-1] == '1);
        if (all_same)
            return x[SAMPLE_BITS-1:0];
        else if (x[AW+1])
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    cbpf_serial_mul #(
        .OPER_BITS (AW),
        .COEF_BITS (COEF_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (mul_load),
        .operand (mul_operand),
        .coef    (mul_coef),
        .status  (mul_stat),
        .result  (mul_result)
    );

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign last_sec = (sec_reg == SEC_W'(MAX_SECTIONS - 1));
    assign used     = (UW'(sections_reg) > UW'(MAX_SECTIONS)) ? UW'(MAX_SECTIONS)
                                                              : UW'(sections_reg);
    assign tap_hit  = ((UW'(sec_reg) + UW'(1)) == used);

    always_comb
    begin
        if (state_reg == cbpf_pkg::S_LP_LOAD)
        begin
            mul_operand = sext(h_reg) - sext(lpo_reg[sec_reg]);
            mul_coef    = lp_gain_reg;
        end
        else
        begin
            mul_operand = sext(hpo_reg[sec_reg]) + sext(v_reg) - sext(hpi_reg[sec_reg]);
            mul_coef    = hp_gain_reg;
        end
        h_next = sat({mul_result[AW], mul_result});
        l_next = sat({{2{lpo_reg[sec_reg][SAMPLE_BITS-1]}}, sext(lpo_reg[sec_reg])}
                     + {mul_result[AW], mul_result});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbpf_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = s_axis_tuser ? cbpf_pkg::S_START : cbpf_pkg::S_HP_LOAD;
            end
            cbpf_pkg::S_START:   state_next = cbpf_pkg::S_WAIT;
            cbpf_pkg::S_HP_LOAD: state_next = cbpf_pkg::S_HP_RUN;
            cbpf_pkg::S_HP_RUN:
            begin
                if (mul_stat.done)
                    state_next = cbpf_pkg::S_LP_LOAD;
            end
            cbpf_pkg::S_LP_LOAD: state_next = cbpf_pkg::S_LP_RUN;
            cbpf_pkg::S_LP_RUN:
            begin
                if (mul_stat.done)
                    state_next = last_sec ? cbpf_pkg::S_WAIT : cbpf_pkg::S_HP_LOAD;
            end
            cbpf_pkg::S_WAIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = cbpf_pkg::S_IDLE;
            end
            default:             state_next = cbpf_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        mul_load      = 1'b0;
        out_load      = 1'b0;
        hp_write      = 1'b0;
        lp_write      = 1'b0;
        start_write   = 1'b0;
        case (state_reg)
            cbpf_pkg::S_IDLE:    s_axis_tready = 1'b1;
            cbpf_pkg::S_START:   start_write   = 1'b1;
            cbpf_pkg::S_HP_LOAD: mul_load      = 1'b1;
            cbpf_pkg::S_HP_RUN:  hp_write      = mul_stat.done;
            cbpf_pkg::S_LP_LOAD: mul_load      = 1'b1;
            cbpf_pkg::S_LP_RUN:  lp_write      = mul_stat.done;
            cbpf_pkg::S_WAIT:    out_load      = !out_valid_reg || m_axis_tready;
            default:             s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbpf_pkg::S_IDLE;
            sec_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                sec_reg <= '0;
            else if (lp_write && !last_sec)
                sec_reg <= sec_reg + SEC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_gain_reg  <= COEF_BITS'(cbpf_pkg::HIGH_PASS_GAIN_RESET);
            lp_gain_reg  <= COEF_BITS'(cbpf_pkg::LOW_PASS_GAIN_RESET);
            sections_reg <= 3'(cbpf_pkg::SECTIONS_IN_USE_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cbpf_pkg::CFG_HIGH_PASS_GAIN:  hp_gain_reg  <= cfg_data;
                cbpf_pkg::CFG_LOW_PASS_GAIN:   lp_gain_reg  <= cfg_data;
                cbpf_pkg::CFG_SECTIONS_IN_USE: sections_reg <= cfg_data[2:0];
                default:                       sections_reg <= sections_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_SECTIONS; s++)
            begin
                hpi_reg[s] <= '0;
                hpo_reg[s] <= '0;
                lpo_reg[s] <= '0;
            end
        end
        else if (start_write)
        begin
            for (int s = 0; s < MAX_SECTIONS; s++)
            begin
                hpi_reg[s] <= v_reg;
                hpo_reg[s] <= v_reg;
                lpo_reg[s] <= v_reg;
            end
        end
        else if (hp_write)
        begin
            hpi_reg[sec_reg] <= v_reg;
            hpo_reg[sec_reg] <= h_next;
        end
        else if (lp_write)
        begin
            lpo_reg[sec_reg] <= l_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg   <= s_axis_tdata[SAMPLE_BITS-1:0];
            tap_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
        else if (hp_write)
        begin
            h_reg <= h_next;
        end
        else if (lp_write)
        begin
            v_reg <= l_next;
            if (tap_hit)
                tap_reg <= l_next;
        end
        if (out_load)
            out_data_reg <= tap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_BITS'(out_data_reg);

    // The shared multiplier is only started when it is free.
    `CBPF_ASSERT(a_load_when_free, clk, rst_n, mul_load |-> !mul_stat.busy)
    // A finished product only ever arrives while the sequencer is waiting for one.
    `CBPF_ASSERT(a_done_in_run, clk, rst_n,
        mul_stat.done |-> (state_reg == cbpf_pkg::S_HP_RUN || state_reg == cbpf_pkg::S_LP_RUN))
    // Every section but the last is followed by the high-pass of the next one.
    `CBPF_ASSERT(a_next_section, clk, rst_n,
        (lp_write && !last_sec) |=> (state_reg == cbpf_pkg::S_HP_LOAD && !$stable(sec_reg)))
    // A restart never involves the multiplier.
    `CBPF_NEVER(a_start_idle_mul, clk, rst_n, start_write && mul_stat.busy)

endmodule

### dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W      = 24;
    localparam int COEF_W        = 16;
    localparam int SECTIONS      = 4;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int QUIET_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 300;
    localparam int PRINT_LIMIT   = 40;
    localparam longint SMP_MAX   = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint SMP_MIN   = -(64'sd1 <<< (SAMPLE_W - 1));
    localparam longint COEF_ONE  = 64'sd1 <<< COEF_W;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_WRITE,
        OP_DRAIN
    } stim_kind_t;

    typedef struct {
        stim_kind_t          kind;
        logic [SAMPLE_W-1:0] sample;
        logic                start;
        logic [1:0]          reg_index;
        logic [COEF_W-1:0]   reg_value;
    } stim_op_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = cbpf_pkg::CFG_HIGH_PASS_GAIN;
    logic [COEF_W-1:0]   cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // Fields from bit 0: sample.
    logic [SAMPLE_W-1:0] s_axis_tdata = '0;
    // Fields from bit 0: start_req.
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // Fields from bit 0: filtered.
    logic [SAMPLE_W-1:0] m_axis_tdata;

    stim_op_t            pending[$];
    logic [SAMPLE_W-1:0] filtered_due[$];

    // Filter state and settings as the block should hold them.
    logic [COEF_W-1:0]          hp_gain = COEF_W'(cbpf_pkg::HIGH_PASS_GAIN_RESET);
    logic [COEF_W-1:0]          lp_gain = COEF_W'(cbpf_pkg::LOW_PASS_GAIN_RESET);
    logic [2:0]                 sections_used = 3'(cbpf_pkg::SECTIONS_IN_USE_RESET);
    logic signed [SAMPLE_W-1:0] hp_last_in [SECTIONS] = '{default: '0};
    logic signed [SAMPLE_W-1:0] hp_last_out [SECTIONS] = '{default: '0};
    logic signed [SAMPLE_W-1:0] lp_last_out [SECTIONS] = '{default: '0};

    int     samples_offered = 0;
    int     samples_taken = 0;
    int     results_checked = 0;
    int     saturated_results = 0;
    int     records = 0;
    int     reg_writes = 0;
    int     settings = 0;
    int     errors = 0;
    int     quiet_cycles = 0;
    int     send_gap = 0;
    int     send_calm_left = 0;
    int     rx_count = 0;
    longint walk_level = 0;
    longint walk_step = 4096;

    cascaded_rc_bandpass_filter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic longint clamp_sample(input longint v);
        if (v > SMP_MAX)
            return SMP_MAX;
        if (v < SMP_MIN)
            return SMP_MIN;
        return v;
    endfunction

    // Division by 2^COEF_W, rounding half up.
    function automatic longint round_coef(input longint p);
        return (p + (COEF_ONE / 2)) >>> COEF_W;
    endfunction

    function automatic logic [SAMPLE_W-1:0] bandpass_predict(
        input logic [SAMPLE_W-1:0] raw,
        input logic                restart
    );
        longint v;
        longint tap;
        longint acc;
        longint h;
        longint l;
        int     taps;
        int     s;
        v = $signed(raw);
        tap = v;
        taps = (sections_used > SECTIONS) ? SECTIONS : int'(sections_used);
        for (s = 0; s < SECTIONS; s++)
        begin
            if (restart)
            begin
                h = v;
                l = v;
            end
            else
            begin
                acc = longint'(hp_last_out[s]) + v - longint'(hp_last_in[s]);
                h = clamp_sample(round_coef(acc * longint'(hp_gain)));
                l = clamp_sample(round_coef(longint'(lp_gain) * h
                    + (COEF_ONE - longint'(lp_gain)) * longint'(lp_last_out[s])));
            end
            hp_last_in[s] = v[SAMPLE_W-1:0];
            hp_last_out[s] = h[SAMPLE_W-1:0];
            lp_last_out[s] = l[SAMPLE_W-1:0];
            v = l;
            if (s + 1 == taps)
                tap = l;
        end
        return tap[SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                   input logic [SAMPLE_W-1:0] want);
        if (errors < PRINT_LIMIT)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what,
                     $signed(got), $signed(want));
        errors++;
    endtask

    function automatic int pick_send_gap();
        int r;
        if (send_calm_left > 0)
        begin
            send_calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            send_calm_left = $urandom_range(20, 120);
            return 0;
        end
        if (r < 58)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 30);
        return $urandom_range(60, 300);
    endfunction

    function automatic int pick_rx_run();
        if ($urandom_range(0, 99) < 5)
            return $urandom_range(500, 3000);
        return $urandom_range(0, 40);
    endfunction

    function automatic int pick_rx_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        if (r < 95)
            return $urandom_range(3, 15);
        return $urandom_range(40, 250);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int                  r;
        logic [SAMPLE_W-1:0] raw;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            raw = SAMPLE_W'($urandom());
            walk_level = $signed(raw);
        end
        else if (r < 12)
        begin
            raw = r[0] ? SAMPLE_W'(SMP_MAX) : SAMPLE_W'(SMP_MIN);
        end
        else
        begin
            walk_level = clamp_sample(walk_level
                + longint'($urandom_range(0, 2 * walk_step)) - walk_step);
            raw = walk_level[SAMPLE_W-1:0];
        end
        return raw;
    endfunction

    function automatic void push_sample(input longint value, input logic start);
        stim_op_t op;
        op.kind = OP_SAMPLE;
        op.sample = value[SAMPLE_W-1:0];
        op.start = start;
        op.reg_index = cbpf_pkg::CFG_HIGH_PASS_GAIN;
        op.reg_value = '0;
        pending = {pending, op};
    endfunction

    function automatic void push_write(input logic [1:0] index, input logic [COEF_W-1:0] value);
        stim_op_t op;
        op.kind = OP_WRITE;
        op.sample = '0;
        op.start = 1'b0;
        op.reg_index = index;
        op.reg_value = value;
        pending = {pending, op};
    endfunction

    function automatic void push_drain();
        stim_op_t op;
        op.kind = OP_DRAIN;
        op.sample = '0;
        op.start = 1'b0;
        op.reg_index = cbpf_pkg::CFG_HIGH_PASS_GAIN;
        op.reg_value = '0;
        pending = {pending, op};
    endfunction

    function automatic logic [COEF_W-1:0] pick_gain(input logic near_one);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                2: return 16'd1;
                default: return 16'h8000;
            endcase
        if (near_one && r < 65)
            return COEF_W'($urandom_range(60000, 65535));
        return COEF_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [COEF_W-1:0] pick_sections();
        logic [COEF_W-1:0] value;
        if ($urandom_range(0, 99) < 80)
            value = COEF_W'($urandom_range(1, SECTIONS));
        else
            value = COEF_W'($urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0)
            value[COEF_W-1:3] = (COEF_W - 3)'($urandom());
        return value;
    endfunction

    function automatic void build_stimulus();
        int random_left;
        int phase;
        int phase_left;
        int rec_len;
        int i;
        logic [COEF_W-1:0] hp_pick;
        logic [COEF_W-1:0] lp_pick;
        logic [COEF_W-1:0] sec_pick;

        // Directed part under the reset settings: extremes, saturation and restarts.
        push_sample(SMP_MAX, 1'b1);
        push_sample(SMP_MIN, 1'b0);
        push_sample(SMP_MAX, 1'b0);
        push_sample(SMP_MIN, 1'b0);
        push_sample(0, 1'b0);
        push_sample(1, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(SMP_MAX, 1'b0);
        push_sample(SMP_MAX, 1'b0);
        push_sample(SMP_MAX, 1'b0);
        push_sample(24'h123456, 1'b0);
        push_sample(-1, 1'b1);
        push_sample(SMP_MIN, 1'b0);
        push_sample(SMP_MIN, 1'b0);
        push_sample(24'h5A5A5A, 1'b0);
        // No sections: the sample passes straight through.
        push_write(cbpf_pkg::CFG_SECTIONS_IN_USE, 16'd0);
        push_sample(24'hA5A5A5, 1'b0);
        push_sample(SMP_MAX, 1'b0);
        push_sample(SMP_MIN, 1'b1);
        // A count beyond the last section acts as all sections.
        push_write(cbpf_pkg::CFG_SECTIONS_IN_USE, 16'd7);
        push_sample(SMP_MAX, 1'b0);
        push_sample(0, 1'b0);
        push_sample(-4096, 1'b0);
        push_write(cbpf_pkg::CFG_SECTIONS_IN_USE, 16'd4);
        push_sample(777, 1'b0);
        push_sample(SMP_MIN, 1'b0);

        random_left = RANDOM_ITEMS;
        phase = 0;
        while (random_left > 0)
        begin
            case (phase)
                0: begin hp_pick = '0;   lp_pick = '1;   sec_pick = 16'd1;    end
                1: begin hp_pick = '1;   lp_pick = '0;   sec_pick = 16'd4;    end
                2: begin hp_pick = '1;   lp_pick = '1;   sec_pick = 16'd5;    end
                3: begin hp_pick = '0;   lp_pick = '0;   sec_pick = 16'hFFF8; end
                4: begin hp_pick = 16'd65503; lp_pick = 16'd28030; sec_pick = 16'hFFFA; end
                default:
                begin
                    hp_pick = pick_gain(1'b1);
                    lp_pick = pick_gain(1'b0);
                    sec_pick = pick_sections();
                end
            endcase
            if (phase < 5 || $urandom_range(0, 9) < 7)
                push_write(cbpf_pkg::CFG_HIGH_PASS_GAIN, hp_pick);
            if (phase < 5 || $urandom_range(0, 9) < 7)
                push_write(cbpf_pkg::CFG_LOW_PASS_GAIN, lp_pick);
            if (phase < 5 || $urandom_range(0, 9) < 7)
                push_write(cbpf_pkg::CFG_SECTIONS_IN_USE, sec_pick);
            case ($urandom_range(0, 3))
                0: walk_step = 64;
                1: walk_step = 4096;
                2: walk_step = 262144;
                default: walk_step = 2097152;
            endcase

            phase_left = $urandom_range(60, 180);
            if (phase_left > random_left)
                phase_left = random_left;
            random_left -= phase_left;
            while (phase_left > 0)
            begin
                rec_len = $urandom_range(5, 80);
                if (rec_len > phase_left)
                    rec_len = phase_left;
                phase_left -= rec_len;
                walk_level = longint'($urandom_range(0, 200000)) - 100000;
                // Most records open with a restart; a few run on from the last state.
                push_sample(pick_sample(), $urandom_range(0, 9) != 0);
                for (i = 1; i < rec_len; i++)
                    push_sample(pick_sample(), $urandom_range(0, 49) == 0);
                if ($urandom_range(0, 24) == 0)
                    push_drain();
            end
            phase++;
        end
    endfunction

    // Sender: one transfer offered at a time, with random gaps between them.
    always @(negedge clk)
    begin
        logic free;
        logic drive_valid;
        logic drive_we;
        free = !s_axis_tvalid || (samples_taken == samples_offered);
        drive_valid = s_axis_tvalid && !free;
        drive_we = 1'b0;
        if (rst_n && free)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
            end
            else if (pending.size() > 0)
            begin
                case (pending[0].kind)
                    OP_SAMPLE:
                    begin
                        s_axis_tdata <= pending[0].sample;
                        s_axis_tuser <= pending[0].start;
                        drive_valid = 1'b1;
                        samples_offered <= samples_offered + 1;
                        send_gap <= pick_send_gap();
                        void'(pending.pop_front());
                    end
                    OP_WRITE:
                    begin
                        if (filtered_due.size() == 0)
                        begin
                            cfg_index <= pending[0].reg_index;
                            cfg_data <= pending[0].reg_value;
                            drive_we = 1'b1;
                            void'(pending.pop_front());
                        end
                    end
                    default:
                    begin
                        if (filtered_due.size() == 0)
                            void'(pending.pop_front());
                    end
                endcase
            end
        end
        s_axis_tvalid <= drive_valid;
        cfg_we <= drive_we;
    end

    // Receiver: ready toggles between runs and stalls of random length.
    always @(negedge clk)
    begin
        if (rx_count > 0)
        begin
            rx_count <= rx_count - 1;
        end
        else
        begin
            m_axis_tready <= !m_axis_tready;
            rx_count <= m_axis_tready ? pick_rx_stall() : pick_rx_run();
        end
    end

    always @(posedge clk)
    begin
        logic [SAMPLE_W-1:0] want;
        logic                moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    cbpf_pkg::CFG_HIGH_PASS_GAIN:  hp_gain = cfg_data;
                    cbpf_pkg::CFG_LOW_PASS_GAIN:   lp_gain = cfg_data;
                    cbpf_pkg::CFG_SECTIONS_IN_USE: sections_used = cfg_data[2:0];
                    default: ;
                endcase
                reg_writes++;
                if (cfg_index == cbpf_pkg::CFG_HIGH_PASS_GAIN)
                    settings++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                if (filtered_due.size() == 0)
                begin
                    report_mismatch("filtered sample with nothing outstanding",
                                    m_axis_tdata, '0);
                end
                else
                begin
                    want = filtered_due.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch("filtered", m_axis_tdata, want);
                    results_checked++;
                    if (want == SAMPLE_W'(SMP_MAX) || want == SAMPLE_W'(SMP_MIN))
                        saturated_results++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                moved = 1'b1;
                filtered_due = {filtered_due, bandpass_predict(s_axis_tdata, s_axis_tuser)};
                samples_taken++;
                if (s_axis_tuser)
                    records++;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, filtered_due.size());
                $display("cascaded_rc_bandpass_filter regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        build_stimulus();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (pending.size() != 0 || s_axis_tvalid || filtered_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Checked %0d filtered samples (%0d at a rail) across %0d restarts.",
                 results_checked, saturated_results, records);
        $display("Made %0d register writes over %0d gain settings; %0d mismatches.",
                 reg_writes, settings, errors);
        if (errors == 0)
            $display("cascaded_rc_bandpass_filter regression: pass");
        else
            $display("cascaded_rc_bandpass_filter regression: fail");
        $finish;
    end

endmodule
